// ===== design/arpc_pkg.sv =====
// Package for the ARP cache: word types, register indexes, status codes
// and protocol constants. No dependencies.
`default_nettype none

package arpc_pkg;

  localparam int SLOT_W     = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 48;

  localparam logic [10:0] ARP_MIN_LEN = 11'd28;
  localparam logic [15:0] HW_ETHERNET = 16'h0001;
  localparam logic [15:0] PROTO_IPV4  = 16'h0800;
  localparam logic [15:0] OP_REQUEST  = 16'h0001;
  localparam logic [31:0] IP_ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [47:0] BCAST_MAC_RST = 48'hFFFF_FFFF_FFFF;

  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_IP  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BCAST_MAC = CFG_IDX_W'(1);

  localparam logic CMD_LEARN   = 1'b0;
  localparam logic CMD_RESOLVE = 1'b1;

  localparam logic [2:0] ST_SHORT_DROP = 3'd0;
  localparam logic [2:0] ST_TYPE_DROP  = 3'd1;
  localparam logic [2:0] ST_LEARNED    = 3'd2;
  localparam logic [2:0] ST_LEARN_REPLY = 3'd3;
  localparam logic [2:0] ST_HIT        = 3'd4;
  localparam logic [2:0] ST_BROADCAST  = 3'd5;
  localparam logic [2:0] ST_MISS       = 3'd6;

  typedef struct packed {
    logic        cmd;
    logic [10:0] frame_len;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [15:0] opcode;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
    logic [31:0] tgt_ip;
    logic [31:0] query_ip;
  } in_word_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [47:0]       mac_out;
    logic [31:0]       ip_out;
    logic [SLOT_W-1:0] slot;
  } out_word_t;

  // Control of the match unit by the sequencer.
  typedef struct packed {
    logic clear;
    logic cmp_en;
  } match_ctl_t;

endpackage

`default_nettype wire

// ===== design/arpc_in_if.sv =====
// Input channel of the ARP cache: valid/ready plus one item word.
// Depends on arpc_pkg.
`default_nettype none

interface arpc_in_if;
  import arpc_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/arpc_out_if.sv =====
// Result channel of the ARP cache: valid/ready plus one result word.
// Depends on arpc_pkg.
`default_nettype none

interface arpc_out_if;
  import arpc_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/arpc_cfg_if.sv =====
// Configuration write channel of the ARP cache: register index and data.
// Depends on arpc_pkg.
`default_nettype none

interface arpc_cfg_if;
  import arpc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/arp_cache_learn_resolve_core.sv =====
// Top level of the ARP cache: sequencer, configuration registers and the
// result register. Uses arpc_pkg, the three channel interfaces,
// arpc_store and arpc_match.
`default_nettype none

// ARP address-resolution cache with ENTRIES entries (2 to 16). Each input
// word either learns the sender mapping of a received ARP header or
// resolves an IP address, and produces exactly one result word. A learn or
// resolve that needs the table walks it one entry per cycle through a
// single compare unit fed by the registered read port of the entry
// memories; the walk ends with the final compare and the sequencer then
// moves to its finishing state, from which the result is loaded into the
// output register. Dropped learn words and broadcast resolves skip the
// walk and go from idle straight to the finishing state. A stalled result
// register holds the sequencer in its finishing state. The block accepts
// one word at a time: in_ch.ready is high only while the sequencer is idle,
// though a new word is taken while an earlier result still waits in the
// output register. The valid flags of all entries are cleared by reset
// together, so no clearing pass follows reset. Configuration writes are
// always accepted and should only be issued while no word is in flight.
module arp_cache_learn_resolve_core #(
  parameter int ENTRIES = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  arpc_in_if.sink    in_ch,
  arpc_out_if.source out_ch,
  arpc_cfg_if.sink   cfg_ch
);
  import arpc_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]    state_r, state_nxt;
  in_word_t      item_r;
  logic [31:0]   local_ip_r;
  logic [47:0]   bcast_mac_r;

  // Table walk: cnt_r is the address being read, the cmp_* registers
  // follow it by one register, in step with the registered read data.
  logic [IW-1:0] cnt_r;
  logic          issue_r;
  logic          cmp_vld_r;
  logic          cmp_last_r;
  logic [IW-1:0] cmp_idx_r;

  logic          out_valid_r;
  out_word_t     out_data_r;

  logic          in_acc;
  logic          in_needs_walk;
  logic          fin_go;
  logic          learn_ok;
  logic [IW-1:0] wr_idx;
  out_word_t     result;

  logic [31:0]   rd_ip;
  logic [47:0]   rd_mac;
  logic          rd_valid;
  match_ctl_t    mctl;
  logic          hit;
  logic [IW-1:0] hit_idx;
  logic [47:0]   hit_mac;
  logic          free_seen;
  logic [IW-1:0] vacant_idx;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // A learn word walks the table only if it passes the header checks, and a
  // resolve word only if it is not the broadcast address.
  always_comb begin
    if (in_ch.data.cmd == CMD_LEARN) begin
      in_needs_walk = (in_ch.data.frame_len >= ARP_MIN_LEN) &&
                      (in_ch.data.hw_type == HW_ETHERNET) &&
                      (in_ch.data.proto_type == PROTO_IPV4);
    end else begin
      in_needs_walk = (in_ch.data.query_ip != IP_ALL_ONES);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_ip_r  <= '0;
      bcast_mac_r <= BCAST_MAC_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      if (cfg_ch.index == REG_LOCAL_IP) begin
        local_ip_r <= cfg_ch.data[31:0];
      end else if (cfg_ch.index == REG_BCAST_MAC) begin
        bcast_mac_r <= cfg_ch.data;
      end
    end
  end

  // The result leaves the sequencer once the output register is free.
  assign fin_go = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = in_needs_walk ? S_SCAN : S_FIN;
        end
      end
      S_SCAN: begin
        if (cmp_vld_r && cmp_last_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      issue_r    <= 1'b0;
      cmp_vld_r  <= 1'b0;
      cmp_last_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      cmp_vld_r  <= issue_r;
      cmp_last_r <= issue_r && (cnt_r == LAST_IDX);
      if (in_acc) begin
        cnt_r   <= '0;
        issue_r <= in_needs_walk;
      end else if (issue_r) begin
        cnt_r   <= cnt_r + IW'(1);
        issue_r <= (cnt_r != LAST_IDX);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_ch.data;
    end
    cmp_idx_r <= cnt_r;
  end

  assign mctl.clear  = in_acc;
  assign mctl.cmp_en = cmp_vld_r;

  arpc_store #(
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (issue_r),
    .rd_addr    (cnt_r),
    .wr_en      (fin_go && learn_ok),
    .wr_addr    (wr_idx),
    .wr_ip      (item_r.sender_ip),
    .wr_mac     (item_r.sender_mac),
    .rd_ip_r    (rd_ip),
    .rd_mac_r   (rd_mac),
    .rd_valid_r (rd_valid)
  );

  arpc_match #(
    .ENTRIES (ENTRIES)
  ) u_match (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (mctl),
    .key          ((item_r.cmd == CMD_LEARN) ? item_r.sender_ip : item_r.query_ip),
    .cmp_idx      (cmp_idx_r),
    .rd_ip        (rd_ip),
    .rd_mac       (rd_mac),
    .rd_valid     (rd_valid),
    .hit_r        (hit),
    .hit_idx_r    (hit_idx),
    .hit_mac_r    (hit_mac),
    .free_r       (free_seen),
    .vacant_idx_r (vacant_idx)
  );

  // An existing entry is updated, else the lowest free one is filled, else
  // entry zero is evicted.
  always_comb begin
    if (hit) begin
      wr_idx = hit_idx;
    end else if (free_seen) begin
      wr_idx = vacant_idx;
    end else begin
      wr_idx = '0;
    end
  end

  assign learn_ok = (item_r.cmd == CMD_LEARN) &&
                    (item_r.frame_len >= ARP_MIN_LEN) &&
                    (item_r.hw_type == HW_ETHERNET) &&
                    (item_r.proto_type == PROTO_IPV4);

  always_comb begin
    result = '0;
    if (item_r.cmd == CMD_LEARN) begin
      if (item_r.frame_len < ARP_MIN_LEN) begin
        result.status = ST_SHORT_DROP;
      end else if (!learn_ok) begin
        result.status = ST_TYPE_DROP;
      end else begin
        result.slot = SLOT_W'(wr_idx);
        if ((item_r.opcode == OP_REQUEST) && (item_r.tgt_ip == local_ip_r)) begin
          result.status  = ST_LEARN_REPLY;
          result.mac_out = item_r.sender_mac;
          result.ip_out  = item_r.sender_ip;
        end else begin
          result.status = ST_LEARNED;
        end
      end
    end else begin
      result.ip_out = item_r.query_ip;
      if (item_r.query_ip == IP_ALL_ONES) begin
        result.status  = ST_BROADCAST;
        result.mac_out = bcast_mac_r;
      end else if (hit) begin
        result.status  = ST_HIT;
        result.mac_out = hit_mac;
        result.slot    = SLOT_W'(hit_idx);
      end else begin
        result.status = ST_MISS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_data_r <= result;
    end
  end

`ifndef ASSERT_OFF
  // Compare results only arrive while the table is being walked.
  a_cmp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> (state_r == S_SCAN))
    else $error("compare result outside table walk");

  // Once reads stop during a walk, the final compare is the one pending.
  a_scan_drain: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) && !issue_r) |-> (cmp_vld_r && cmp_last_r))
    else $error("table walk stalled without a final compare");

  // A new result word is only loaded from the finishing state.
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
    else $error("result offered without finishing an item");
`endif

endmodule

`default_nettype wire

// ===== design/arpc_store.sv =====
// Entry store of the ARP cache: IP and MAC memories with one write and one
// registered read port, and per-entry valid flags cleared by reset.
`default_nettype none

module arpc_store #(
  parameter int ENTRIES = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        rd_en,
  input  wire logic [$clog2(ENTRIES)-1:0]  rd_addr,
  input  wire logic                        wr_en,
  input  wire logic [$clog2(ENTRIES)-1:0]  wr_addr,
  input  wire logic [31:0]                 wr_ip,
  input  wire logic [47:0]                 wr_mac,
  output logic [31:0]                      rd_ip_r,
  output logic [47:0]                      rd_mac_r,
  output logic                             rd_valid_r
);

  logic [31:0]        ip_mem  [ENTRIES];
  logic [47:0]        mac_mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ip_mem[wr_addr]  <= wr_ip;
      mac_mem[wr_addr] <= wr_mac;
    end
    if (rd_en) begin
      rd_ip_r  <= ip_mem[rd_addr];
      rd_mac_r <= mac_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/arpc_match.sv =====
// Shared compare unit of the ARP cache: compares one stored entry a cycle
// while cmp_en is high with the key and keeps the first hit and the first free entry.
`default_nettype none

module arpc_match #(
  parameter int ENTRIES = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire arpc_pkg::match_ctl_t           ctl,
  input  wire logic [31:0]                    key,
  input  wire logic [$clog2(ENTRIES)-1:0]     cmp_idx,
  input  wire logic [31:0]                    rd_ip,
  input  wire logic [47:0]                    rd_mac,
  input  wire logic                           rd_valid,
  output logic                                hit_r,
  output logic [$clog2(ENTRIES)-1:0]          hit_idx_r,
  output logic [47:0]                         hit_mac_r,
  output logic                                free_r,
  output logic [$clog2(ENTRIES)-1:0]          vacant_idx_r
);
  import arpc_pkg::*;

  logic eq;

  assign eq = rd_valid && (rd_ip == key);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else if (ctl.clear) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else if (ctl.cmp_en) begin
      if (eq && !hit_r) begin
        hit_r <= 1'b1;
      end
      if (!rd_valid && !free_r) begin
        free_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmp_en && !ctl.clear) begin
      if (eq && !hit_r) begin
        hit_idx_r <= cmp_idx;
        hit_mac_r <= rd_mac;
      end
      if (!rd_valid && !free_r) begin
        vacant_idx_r <= cmp_idx;
      end
    end
  end

endmodule

`default_nettype wire
